// File: sv/sad_pkg.sv
package sad_pkg;

    localparam logic [31:0] LOAD_BIT     = 32'h0010_0000;
    localparam logic [31:0] UP_BIT       = 32'h0080_0000;
    localparam logic [31:0] IMM_MASK     = 32'h0F00_0000;
    localparam logic [31:0] IMM_MATCH    = 32'h0500_0000;
    localparam logic [31:0] POST_MASK    = 32'h0D20_0000;
    localparam logic [31:0] POST_MATCH   = 32'h0400_0000;
    localparam logic [31:0] SCALED_MASK  = 32'h0F00_0000;
    localparam logic [31:0] SCALED_MATCH = 32'h0700_0000;
    localparam logic [31:0] MISC_MASK    = 32'h0F60_0F90;
    localparam logic [31:0] MISC_MATCH   = 32'h0100_0090;
    localparam logic [31:0] IMM12_MASK   = 32'h0000_0FFF;

    // address form codes
    localparam logic [1:0] FORM_IMM    = 2'd0;
    localparam logic [1:0] FORM_POST   = 2'd1;
    localparam logic [1:0] FORM_SCALED = 2'd2;
    localparam logic [1:0] FORM_MISC   = 2'd3;

    // shift kinds
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic        decoded;
        logic [1:0]  form;
        logic        up;
        logic [1:0]  kind;
        logic [4:0]  amt;
        logic [11:0] imm12;
        logic [3:0]  data_idx;
    } t_dec;

endpackage

// File: sv/store_address_decode.sv
// Three registered stages from input transfer to result valid (decode, shift, add).
// Throughput: one instruction per cycle while i_stall is low; the three stages advance
// independently, so a bubble is filled even while the output is stalled.
// The barrel shifter and the 32-bit add each own a stage.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
module store_address_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_index_value,
    input  logic [31:0] i_data_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_decoded,
    output logic [31:0] o_access_address,
    output logic [31:0] o_store_value,
    output logic [3:0]  o_data_reg_index,
    output logic [1:0]  o_address_form
);

    sad_pkg::t_dec w_dec;
    logic [31:0]   w_shift;

    logic          r_v1, r_v2, r_v3;
    logic          w_adv1, w_adv2, w_adv3;

    sad_pkg::t_dec r_dec1;
    logic [31:0]   r_base1, r_idx1, r_data1;

    sad_pkg::t_dec r_dec2;
    logic [31:0]   r_base2, r_data2, r_disp2;
    logic [31:0]   n_disp2;

    logic          r_decoded;
    logic [31:0]   r_addr, r_store;
    logic [3:0]    r_didx;
    logic [1:0]    r_form;
    logic [31:0]   n_addr;

    // a stage loads when its successor is free or moving
    assign w_adv3 = !r_v3 || !i_stall;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_stall = !w_adv1;

    sad_decode u_decode (
        .i_instruction (i_instruction),
        .o_dec         (w_dec)
    );

    sad_shift u_shift (
        .i_kind (r_dec1.kind),
        .i_amt  (r_dec1.amt),
        .i_val  (r_idx1),
        .o_val  (w_shift)
    );

    always_comb begin
        case (r_dec1.form)
            sad_pkg::FORM_IMM:    n_disp2 = {20'd0, r_dec1.imm12};
            sad_pkg::FORM_POST:   n_disp2 = '0;
            sad_pkg::FORM_SCALED: n_disp2 = w_shift;
            sad_pkg::FORM_MISC:   n_disp2 = r_idx1;
            default:              n_disp2 = '0;
        endcase
    end

    assign n_addr = r_dec2.up ? (r_base2 + r_disp2) : (r_base2 - r_disp2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_dec1  <= w_dec;
            r_base1 <= i_base_value;
            r_idx1  <= i_index_value;
            r_data1 <= i_data_value;
        end
        if (w_adv2) begin
            r_dec2  <= r_dec1;
            r_base2 <= r_base1;
            r_data2 <= r_data1;
            r_disp2 <= n_disp2;
        end
        if (w_adv3) begin
            r_decoded <= r_dec2.decoded;
            r_addr    <= r_dec2.decoded ? n_addr : '0;
            r_store   <= r_dec2.decoded ? r_data2 : '0;
            r_didx    <= r_dec2.decoded ? r_dec2.data_idx : '0;
            r_form    <= r_dec2.decoded ? r_dec2.form : '0;
        end
    end

    assign o_valid          = r_v3;
    assign o_decoded        = r_decoded;
    assign o_access_address = r_addr;
    assign o_store_value    = r_store;
    assign o_data_reg_index = r_didx;
    assign o_address_form   = r_form;

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("input stalled with empty first stage");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && i_stall |=> r_v3)
        else $error("stalled result dropped");

    a_post_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_dec2.decoded && r_dec2.form == sad_pkg::FORM_POST |-> r_disp2 == '0)
        else $error("post-indexed offset not zero");

    a_undecoded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_decoded |-> r_addr == '0 && r_store == '0 && r_didx == '0 && r_form == '0)
        else $error("undecoded result not cleared");

endmodule

// File: sv/sad_decode.sv
module sad_decode (
    input  logic [31:0]   i_instruction,
    output sad_pkg::t_dec o_dec
);

    logic [31:0] w_imm12;

    assign w_imm12 = i_instruction & sad_pkg::IMM12_MASK;

    always_comb begin
        o_dec          = '0;
        o_dec.up       = (i_instruction & sad_pkg::UP_BIT) != '0;
        o_dec.kind     = i_instruction[6:5];
        o_dec.amt      = i_instruction[11:7];
        o_dec.imm12    = w_imm12[11:0];
        o_dec.data_idx = i_instruction[15:12];
        // first matching form wins; loads never decode
        if ((i_instruction & sad_pkg::LOAD_BIT) != '0) begin
            o_dec.decoded = 1'b0;
        end else if ((i_instruction & sad_pkg::IMM_MASK) == sad_pkg::IMM_MATCH) begin
            o_dec.decoded = 1'b1;
            o_dec.form    = sad_pkg::FORM_IMM;
        end else if ((i_instruction & sad_pkg::POST_MASK) == sad_pkg::POST_MATCH) begin
            o_dec.decoded = 1'b1;
            o_dec.form    = sad_pkg::FORM_POST;
        end else if ((i_instruction & sad_pkg::SCALED_MASK) == sad_pkg::SCALED_MATCH) begin
            o_dec.decoded = 1'b1;
            o_dec.form    = sad_pkg::FORM_SCALED;
        end else if ((i_instruction & sad_pkg::MISC_MASK) == sad_pkg::MISC_MATCH) begin
            o_dec.decoded = 1'b1;
            o_dec.form    = sad_pkg::FORM_MISC;
        end else begin
            o_dec.decoded = 1'b0;
        end
    end

endmodule

// File: sv/sad_shift.sv
module sad_shift (
    input  logic [1:0]  i_kind,
    input  logic [4:0]  i_amt,
    input  logic [31:0] i_val,
    output logic [31:0] o_val
);

    logic [63:0] w_dbl;
    logic [63:0] w_rot;

    assign w_dbl = {i_val, i_val};
    assign w_rot = w_dbl >> i_amt;

    always_comb begin
        case (i_kind)
            sad_pkg::SH_LSL: begin
                o_val = i_val << i_amt;
            end
            sad_pkg::SH_LSR: begin
                // zero amount encodes a shift of 32
                o_val = (i_amt == '0) ? '0 : (i_val >> i_amt);
            end
            sad_pkg::SH_ASR: begin
                if (i_amt == '0) begin
                    o_val = {32{i_val[31]}};
                end else begin
                    o_val = $unsigned($signed(i_val) >>> i_amt);
                end
            end
            sad_pkg::SH_ROR: begin
                // zero amount is rotate-with-extend, taken as zero offset
                o_val = (i_amt == '0) ? '0 : w_rot[31:0];
            end
            default: begin
                o_val = '0;
            end
        endcase
    end

endmodule

// File: tb/store_address_decode_tb.sv
`timescale 1ns / 100ps

module store_address_decode_tb;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1032;

    typedef struct packed {
        logic        decoded;
        logic [31:0] address;
        logic [31:0] value;
        logic [3:0]  reg_idx;
        logic [1:0]  form;
    } t_store_result;

    // instruction classes for the random part
    typedef enum int {
        PICK_IMM,
        PICK_POST,
        PICK_SCALED,
        PICK_MISC,
        PICK_LOAD,
        PICK_ANY
    } t_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_instruction = '0;
    logic [31:0] i_base_value = '0;
    logic [31:0] i_index_value = '0;
    logic [31:0] i_data_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_decoded;
    logic [31:0] o_access_address;
    logic [31:0] o_store_value;
    logic [3:0]  o_data_reg_index;
    logic [1:0]  o_address_form;

    t_store_result pending_stores[$];
    bit            mismatch_seen = 1'b0;
    int unsigned   idle_pct = 0;
    int unsigned   stall_pct = 0;
    int unsigned   cycle_count = 0;

    store_address_decode dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_instruction    (i_instruction),
        .i_base_value     (i_base_value),
        .i_index_value    (i_index_value),
        .i_data_value     (i_data_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_decoded        (o_decoded),
        .o_access_address (o_access_address),
        .o_store_value    (o_store_value),
        .o_data_reg_index (o_data_reg_index),
        .o_address_form   (o_address_form)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [31:0] shifted_index(input logic [31:0] instr,
                                                  input logic [31:0] val);
        logic [4:0]  amt;
        logic [31:0] sign_fill;
        logic [31:0] res;
        amt       = instr[11:7];
        sign_fill = {32{val[31]}};
        // a zero amount on LSR/ASR means 32; on ROR it means RRX, taken as 0
        case (instr[6:5])
            sad_pkg::SH_LSL: res = val << amt;
            sad_pkg::SH_LSR: res = (amt == 0) ? '0 : val >> amt;
            sad_pkg::SH_ASR: res = (amt == 0) ? sign_fill
                                     : (val >> amt) | (sign_fill << (6'd32 - amt));
            sad_pkg::SH_ROR: res = (amt == 0) ? '0 : (val >> amt) | (val << (6'd32 - amt));
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic t_store_result predict_store(input logic [31:0] instr,
                                                    input logic [31:0] base,
                                                    input logic [31:0] idx,
                                                    input logic [31:0] data);
        t_store_result r;
        logic [31:0]   offset;
        logic [1:0]    form;
        r = '0;
        if ((instr & sad_pkg::LOAD_BIT) != 0)
            return r;
        if ((instr & sad_pkg::IMM_MASK) == sad_pkg::IMM_MATCH) begin
            offset = instr & sad_pkg::IMM12_MASK;
            form   = sad_pkg::FORM_IMM;
        end else if ((instr & sad_pkg::POST_MASK) == sad_pkg::POST_MATCH) begin
            offset = '0;
            form   = sad_pkg::FORM_POST;
        end else if ((instr & sad_pkg::SCALED_MASK) == sad_pkg::SCALED_MATCH) begin
            offset = shifted_index(instr, idx);
            form   = sad_pkg::FORM_SCALED;
        end else if ((instr & sad_pkg::MISC_MASK) == sad_pkg::MISC_MATCH) begin
            offset = idx;
            form   = sad_pkg::FORM_MISC;
        end else begin
            return r;
        end
        if ((instr & sad_pkg::UP_BIT) == 0)
            offset = -offset;
        r.decoded = 1'b1;
        r.address = base + offset;
        r.value   = data;
        r.reg_idx = instr[15:12];
        r.form    = form;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    // result side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        t_store_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_stores.size() == 0) begin
                $display("%0t: unexpected result expected none actual addr %h form %0d",
                         $time, o_access_address, o_address_form);
                mismatch_seen = 1'b1;
            end else begin
                want = pending_stores.pop_front();
                check_field("decoded", 32'(want.decoded), 32'(o_decoded));
                check_field("access_address", want.address, o_access_address);
                check_field("store_value", want.value, o_store_value);
                check_field("data_reg_index", 32'(want.reg_idx), 32'(o_data_reg_index));
                check_field("address_form", 32'(want.form), 32'(o_address_form));
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // entered right after a rising edge; returns right after the transfer edge
    task automatic send_store(input logic [31:0] instr, input logic [31:0] base,
                              input logic [31:0] idx, input logic [31:0] data);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_instruction <= instr;
        i_base_value  <= base;
        i_index_value <= idx;
        i_data_value  <= data;
        do @(posedge i_clk); while (o_stall);
        pending_stores.push_back(predict_store(instr, base, idx, data));
    endtask

    function automatic logic [31:0] scaled_word(input logic [1:0] kind,
                                                input logic [4:0] amt, input logic up);
        logic [31:0] w;
        w        = sad_pkg::SCALED_MATCH;
        w[23]    = up;
        w[15:12] = 4'hA;
        w[11:7]  = amt;
        w[6:5]   = kind;
        w[3:0]   = 4'h3;
        return w;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_immediate();
        // offset wraps past the top and below zero
        send_store(sad_pkg::IMM_MATCH | sad_pkg::UP_BIT | 32'h0000_FFFF,
                   32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
        send_store(sad_pkg::IMM_MATCH | 32'h0000_0FFF, 32'h0000_0000, '0, 32'h1234_5678);
        send_store(sad_pkg::IMM_MATCH | sad_pkg::UP_BIT, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h0000_0000);
    endtask

    task automatic test_post_indexed();
        send_store(sad_pkg::POST_MATCH | sad_pkg::UP_BIT | 32'h0000_5FFF,
                   32'hDEAD_BEEF, '1, 32'hA5A5_A5A5);
        send_store(sad_pkg::POST_MATCH | 32'h0200_7ABC, 32'h0000_0010, '1, 32'h5A5A_5A5A);
    endtask

    task automatic test_scaled_shifts();
        send_store(scaled_word(sad_pkg::SH_LSL, 5'd0, 1'b1), 32'h1000, 32'hFFFF_FFFF, 32'h1);
        send_store(scaled_word(sad_pkg::SH_LSL, 5'd31, 1'b0), 32'h1000, 32'h0000_0003, 32'h2);
        send_store(scaled_word(sad_pkg::SH_LSR, 5'd0, 1'b1), 32'h1000, 32'hFFFF_FFFF, 32'h3);
        send_store(scaled_word(sad_pkg::SH_LSR, 5'd1, 1'b1), 32'h1000, 32'hFFFF_FFFF, 32'h4);
        send_store(scaled_word(sad_pkg::SH_ASR, 5'd0, 1'b1), 32'h1000, 32'h8000_0000, 32'h5);
        send_store(scaled_word(sad_pkg::SH_ASR, 5'd0, 1'b0), 32'h1000, 32'h7FFF_FFFF, 32'h6);
        send_store(scaled_word(sad_pkg::SH_ASR, 5'd31, 1'b1), 32'h1000, 32'h8000_0001, 32'h7);
        send_store(scaled_word(sad_pkg::SH_ROR, 5'd0, 1'b1), 32'h1000, 32'hFFFF_FFFF, 32'h8);
        send_store(scaled_word(sad_pkg::SH_ROR, 5'd1, 1'b1), 32'h1000, 32'h0000_0001, 32'h9);
        send_store(scaled_word(sad_pkg::SH_ROR, 5'd31, 1'b0), 32'h1000, 32'h8000_0001, 32'hA);
    endtask

    task automatic test_misc_register();
        send_store(sad_pkg::MISC_MATCH | sad_pkg::UP_BIT | 32'h0000_F0BF,
                   32'h0000_0001, '1, 32'hCAFE_F00D);
        send_store(sad_pkg::MISC_MATCH | 32'h0000_00F0, 32'h0000_0000, '1, 32'h0BAD_F00D);
    endtask

    task automatic test_rejected_words();
        // loads on the immediate, scaled and misc forms, then words that match no form
        send_store(sad_pkg::IMM_MATCH | sad_pkg::UP_BIT | sad_pkg::LOAD_BIT | 32'h0000_F123,
                   32'h100, 32'h4, '1);
        send_store(scaled_word(sad_pkg::SH_ASR, 5'd3, 1'b1) | sad_pkg::LOAD_BIT,
                   32'h100, 32'h8000_0000, '1);
        send_store(sad_pkg::MISC_MATCH | sad_pkg::LOAD_BIT | 32'h0000_00F0,
                   32'h100, 32'h4, '1);
        send_store(32'hFFFF_FFFF, '1, '1, '1);
        send_store(32'h0000_0000, '1, '1, '1);
        send_store(32'h0100_0000, '1, '1, '1);
        send_store(sad_pkg::POST_MATCH | 32'h0020_0000, '1, '1, '1);
        send_store(32'hEF00_0000, '1, '1, '1);
    endtask

    task automatic test_random(input int count);
        t_pick       pick;
        logic [31:0] instr;
        for (int n = 0; n < count; n++) begin
            pick  = t_pick'($urandom_range(PICK_ANY));
            instr = $urandom;
            case (pick)
                PICK_IMM: instr = (instr & ~sad_pkg::IMM_MASK & ~sad_pkg::LOAD_BIT)
                                  | sad_pkg::IMM_MATCH;
                PICK_POST: instr = (instr & ~sad_pkg::POST_MASK & ~sad_pkg::LOAD_BIT)
                                   | sad_pkg::POST_MATCH;
                PICK_SCALED: begin
                    instr = (instr & ~sad_pkg::SCALED_MASK & ~sad_pkg::LOAD_BIT)
                            | sad_pkg::SCALED_MATCH;
                    if ($urandom_range(3) == 0)
                        instr[11:7] = 5'd0;
                end
                PICK_MISC: instr = (instr & ~sad_pkg::MISC_MASK & ~sad_pkg::LOAD_BIT)
                                   | sad_pkg::MISC_MATCH;
                PICK_LOAD: instr = (instr & ~sad_pkg::IMM_MASK) | sad_pkg::LOAD_BIT
                                   | ($urandom_range(1) ? sad_pkg::IMM_MATCH
                                                        : sad_pkg::SCALED_MATCH);
                default: ;
            endcase
            send_store(instr, rand_operand(), rand_operand(), rand_operand());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_immediate();
        test_post_indexed();
        test_scaled_shifts();
        idle_pct  = 26;
        stall_pct = 26;
        test_misc_register();
        test_rejected_words();

        idle_pct  = 0;
        stall_pct = 0;
        test_random(RANDOM_ITEMS / 4);
        idle_pct  = 83;
        test_random(RANDOM_ITEMS / 4);
        idle_pct  = 0;
        stall_pct = 83;
        test_random(RANDOM_ITEMS / 4);
        idle_pct  = 26;
        stall_pct = 26;
        test_random(RANDOM_ITEMS / 4);

        i_valid <= 1'b0;
        while (pending_stores.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!mismatch_seen && pending_stores.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
